// File: sv/bounded_best_cost_list_macros.svh
// Assertion macros shared by the bounded best-cost list RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef BOUNDED_BEST_COST_LIST_MACROS_SVH
`define BOUNDED_BEST_COST_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BBCL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbcl same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BBCL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbcl next-cycle check failed");

`endif

// File: sv/bbcl_pkg.sv
// Package for the bounded best-cost list: sizes, command codes and payload types.
// Used by bbcl_cell and bounded_best_cost_list; depends on nothing else.
package bbcl_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int COST_W     = 24;
    localparam int STEP_W     = 16;
    localparam int TAG_W      = 16;
    localparam int RIDX_W     = 4;
    localparam int KCNT_W     = 5;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic              cmd;
        logic [STEP_W-1:0] step_cost;
        logic              last_step;
        logic [TAG_W-1:0]  solution_tag;
        logic [RIDX_W-1:0] read_index;
    } in_t;

    typedef struct packed {
        logic              inserted;
        logic              dropped;
        logic [RIDX_W-1:0] insert_position;
        logic [COST_W-1:0] entry_cost;
        logic [TAG_W-1:0]  entry_tag;
        logic              entry_valid;
        logic [KCNT_W-1:0] kept_count;
    } out_t;

endpackage

// File: sv/bbcl_cell.sv
// One cell of the sorted list: holds one kept entry and compares it with a new total.
// Depends on bbcl_pkg for the entry type and widths.
module bbcl_cell
    import bbcl_pkg::*;
(
    input  logic              clk,
    input  logic              insert_en,
    input  logic              occupied,
    input  logic [COST_W-1:0] new_total,
    input  logic [TAG_W-1:0]  new_tag,
    input  logic              prev_stay,
    input  entry_t            prev_entry,
    output logic              stay,
    output entry_t            entry
);

    entry_t entry_reg;
    entry_t entry_next;

    assign stay  = occupied && (entry_reg.cost <= new_total);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (insert_en && !stay)
        begin
            if (prev_stay)
            begin
                entry_next.cost = new_total;
                entry_next.tag  = new_tag;
            end
            else
            begin
                entry_next = prev_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: sv/bounded_best_cost_list.sv
// Top level of the bounded best-cost list: running total, count, cell chain, output register.
// Depends on bbcl_pkg, bbcl_cell and bounded_best_cost_list_macros.svh.
//
// The block keeps up to LIST_DEPTH finished solutions sorted by ascending total cost in a
// row of cells that all compare against the new total and shift in the same cycle. A step,
// a finishing step with its insertion, or a read is taken whenever the output register is
// empty or being emptied, so one transaction enters per cycle while results are consumed.
// Results appear in the cycle after acceptance from a registered output; a step without
// last_step produces none. The running total saturates at the top of its 24-bit range.
`include "bounded_best_cost_list_macros.svh"

module bounded_best_cost_list
    import bbcl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    logic [COST_W-1:0] total_reg;
    logic [COST_W-1:0] total_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_t              out_reg;
    out_t              out_next;

    logic              accept;
    logic [COST_W:0]   sum_wide;
    logic [COST_W-1:0] sum_sat;
    logic              finish;
    logic              drop;
    logic              insert_en;
    logic [CNT_W-1:0]  pos;
    logic [31:0]       pos_wide;
    logic [31:0]       cnt_wide;
    logic [31:0]       ridx_wide;
    logic              read_hit;
    entry_t            read_entry;

    logic              occupied [LIST_DEPTH];
    logic              stay     [LIST_DEPTH];
    entry_t            cells    [LIST_DEPTH];

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign sum_wide = {1'b0, total_reg} + (COST_W + 1)'(in_data.step_cost);
    assign sum_sat  = sum_wide[COST_W] ? COST_MAX : sum_wide[COST_W-1:0];
    assign finish   = accept && (in_data.cmd == CMD_ADD) && in_data.last_step;

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++)
        begin : g_cell
            assign occupied[gi] = CNT_W'(gi) < count_reg;
            if (gi == 0)
            begin : g_head
                bbcl_cell u_cell (
                    .clk        (clk),
                    .insert_en  (insert_en),
                    .occupied   (occupied[gi]),
                    .new_total  (sum_sat),
                    .new_tag    (in_data.solution_tag),
                    .prev_stay  (1'b1),
                    .prev_entry (cells[gi]),
                    .stay       (stay[gi]),
                    .entry      (cells[gi])
                );
            end
            else
            begin : g_body
                bbcl_cell u_cell (
                    .clk        (clk),
                    .insert_en  (insert_en),
                    .occupied   (occupied[gi]),
                    .new_total  (sum_sat),
                    .new_tag    (in_data.solution_tag),
                    .prev_stay  (stay[gi-1]),
                    .prev_entry (cells[gi-1]),
                    .stay       (stay[gi]),
                    .entry      (cells[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        pos = count_reg;
        for (int i = LIST_DEPTH - 1; i >= 0; i--)
        begin
            if (occupied[i] && !stay[i])
            begin
                pos = CNT_W'(i);
            end
        end
    end

    assign drop      = (count_reg == CNT_W'(LIST_DEPTH)) && (pos == count_reg);
    assign insert_en = finish && !drop;
    assign pos_wide  = 32'(pos);

    assign ridx_wide = 32'(in_data.read_index);
    assign cnt_wide  = 32'(count_reg);
    assign read_hit  = ridx_wide < cnt_wide;

    always_comb
    begin
        read_entry = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (i < (1 << RIDX_W) && RIDX_W'(i) == in_data.read_index)
            begin
                read_entry = cells[i];
            end
        end
    end

    always_comb
    begin
        total_next     = total_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (accept)
        begin
            out_next = '0;
            if (in_data.cmd == CMD_READ)
            begin
                out_valid_next = 1'b1;
                if (read_hit)
                begin
                    out_next.entry_cost  = read_entry.cost;
                    out_next.entry_tag   = read_entry.tag;
                    out_next.entry_valid = 1'b1;
                end
                out_next.kept_count = cnt_wide[KCNT_W-1:0];
            end
            else if (!in_data.last_step)
            begin
                total_next = sum_sat;
                out_next   = out_reg;
            end
            else
            begin
                total_next     = '0;
                out_valid_next = 1'b1;
                if (drop)
                begin
                    out_next.dropped    = 1'b1;
                    out_next.kept_count = cnt_wide[KCNT_W-1:0];
                end
                else
                begin
                    out_next.inserted        = 1'b1;
                    out_next.insert_position = pos_wide[RIDX_W-1:0];
                    if (count_reg != CNT_W'(LIST_DEPTH))
                    begin
                        count_next          = count_reg + CNT_W'(1);
                        out_next.kept_count = KCNT_W'(cnt_wide + 32'd1);
                    end
                    else
                    begin
                        out_next.kept_count = cnt_wide[KCNT_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    `BBCL_ASSERT_NOW(a_ins_drop_excl, out_valid_reg, !(out_reg.inserted && out_reg.dropped))
    `BBCL_ASSERT_NOW(a_ins_no_entry, out_valid_reg && out_reg.inserted, !out_reg.entry_valid)
    `BBCL_ASSERT_NEXT(a_total_clear, finish, total_reg == '0)
    `BBCL_ASSERT_NEXT(a_drop_full, finish && drop, count_reg == CNT_W'(LIST_DEPTH))

    generate
        for (gi = 1; gi < LIST_DEPTH; gi++)
        begin : g_order_chk
            `BBCL_ASSERT_NOW(a_sorted, occupied[gi], cells[gi-1].cost <= cells[gi].cost)
        end
    endgenerate

endmodule
